### hdl/fsfl_pkg.sv
// Package for the fixed-slot free-list allocator.
// Holds field widths, region constants, status and mode codes and the
// structs passed between the controller, link memory and divider.
package fsfl_pkg;

  // Region geometry. PAGE_BYTES must be a power of two.
  localparam int MAX_SLOTS    = 4096;
  localparam int PAGE_BYTES   = 4096;
  localparam int HEADER_BYTES = 32;

  localparam int MODE_W   = 2;
  localparam int INDEX_W  = 12;
  localparam int STATUS_W = 2;
  localparam int OFFSET_W = 29;
  localparam int COUNT_W  = 13;
  localparam int SIZE_W   = 16;

  localparam int ADDR_W = $clog2(MAX_SLOTS);
  localparam int LINK_W = $clog2(MAX_SLOTS + 1);
  localparam int PROD_W = INDEX_W + SIZE_W;
  localparam int NUM_W  = 18;
  localparam int STEP_W = $clog2(NUM_W + 1);

  localparam logic [LINK_W-1:0] LIST_EMPTY   = LINK_W'(MAX_SLOTS);
  localparam logic [SIZE_W-1:0] SIZE_RESET   = SIZE_W'(16);

  localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REBUILD = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [LINK_W-1:0] data;
  } link_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } link_rd_t;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  numer;
    logic [SIZE_W-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [NUM_W-1:0]    quotient;
  } div_rsp_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                grant;
    logic [INDEX_W-1:0]  granted;
    logic [PROD_W-1:0]   product;
    logic [COUNT_W-1:0]  slot_count;
  } resp_t;

endpackage

### hdl/fsfl_link_mem.sv
// Link memory of the free list: one write port and one read port.
// Read data is registered, so it appears in the cycle after the read.
// Depends on fsfl_pkg.
module fsfl_link_mem (
  input  logic                      clk,
  input  fsfl_pkg::link_wr_t        wr,
  input  fsfl_pkg::link_rd_t        rd,
  output logic [fsfl_pkg::LINK_W-1:0] rd_data
);
  import fsfl_pkg::*;

  logic [LINK_W-1:0] mem [MAX_SLOTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

### hdl/fsfl_div.sv
// Restoring divider used to size the region at a rebuild.
// One quotient bit per cycle; done pulses when the quotient is ready.
// Depends on fsfl_pkg.
module fsfl_div (
  input  logic               clk,
  input  logic               rst,
  input  fsfl_pkg::div_req_t req,
  output fsfl_pkg::div_rsp_t rsp
);
  import fsfl_pkg::*;

  logic [NUM_W-1:0]  quot;
  logic [SIZE_W-1:0] rem;
  logic [SIZE_W-1:0] denom;
  logic [STEP_W-1:0] count;
  logic              busy;
  logic              done;
  logic [SIZE_W:0]   trial;
  logic              fits;

  assign trial = {rem, quot[NUM_W-1]};
  assign fits  = trial >= {1'b0, denom};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        quot  <= req.numer;
        rem   <= '0;
        denom <= req.denom;
        count <= STEP_W'(NUM_W);
        busy  <= 1'b1;
      end else if (busy) begin
        quot  <= {quot[NUM_W-2:0], fits};
        rem   <= fits ? SIZE_W'(trial - {1'b0, denom}) : trial[SIZE_W-1:0];
        count <= count - STEP_W'(1);
        if (count == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quot;

endmodule

### hdl/fsfl_ctrl.sv
// Sequencer of the allocator: holds the list head, capacity and slot size,
// drives the link memory and divider and prepares one response per word.
// Depends on fsfl_pkg.
module fsfl_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [fsfl_pkg::SIZE_W-1:0]   cfg_write_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [fsfl_pkg::MODE_W-1:0]   mode,
  input  logic [fsfl_pkg::INDEX_W-1:0]  slot_index,
  output fsfl_pkg::link_wr_t            link_wr,
  output fsfl_pkg::link_rd_t            link_rd,
  input  logic [fsfl_pkg::LINK_W-1:0]   link_data,
  output fsfl_pkg::div_req_t            div_req,
  input  fsfl_pkg::div_rsp_t            div_rsp,
  output logic                          resp_valid,
  input  logic                          resp_ready,
  output fsfl_pkg::resp_t               resp
);
  import fsfl_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC_RD,
    ST_DIVIDE,
    ST_CHAIN,
    ST_RESP
  } state_t;

  localparam logic [NUM_W-1:0] PAGE_MASK = ~(NUM_W'(PAGE_BYTES - 1));

  state_t              state;
  logic [LINK_W-1:0]   head;
  logic [COUNT_W-1:0]  capacity;
  logic [SIZE_W-1:0]   slot_size;
  logic [SIZE_W-1:0]   built_size;
  logic [ADDR_W-1:0]   chain_idx;
  logic [STATUS_W-1:0] status;
  logic                grant;
  logic [INDEX_W-1:0]  granted;
  logic [PROD_W-1:0]   product;

  logic                accept;
  logic                alloc_ok;
  logic                free_ok;
  logic [NUM_W-1:0]    total;
  logic [NUM_W-1:0]    rounded;
  logic [COUNT_W-1:0]  cap_next;
  logic [COUNT_W-1:0]  chain_succ;
  logic                chain_last;

  assign accept   = in_valid && (state == ST_IDLE);
  assign in_stall = (state != ST_IDLE);
  assign alloc_ok = head < LINK_W'(capacity);
  assign free_ok  = {1'b0, slot_index} < capacity;

  assign total   = NUM_W'(HEADER_BYTES) + NUM_W'(slot_size) + NUM_W'(PAGE_BYTES - 1);
  assign rounded = total & PAGE_MASK;

  assign cap_next = (div_rsp.quotient >= NUM_W'(MAX_SLOTS)) ? COUNT_W'(MAX_SLOTS)
                                                            : div_rsp.quotient[COUNT_W-1:0];
  assign chain_succ = COUNT_W'(chain_idx) + COUNT_W'(1);
  assign chain_last = chain_succ == capacity;

  always_comb begin
    link_wr.en   = 1'b0;
    link_wr.addr = slot_index;
    link_wr.data = head;
    if (accept && mode == MODE_FREE && free_ok) begin
      link_wr.en = 1'b1;
    end else if (state == ST_CHAIN) begin
      link_wr.en   = 1'b1;
      link_wr.addr = chain_idx;
      link_wr.data = chain_last ? LIST_EMPTY : LINK_W'(chain_succ);
    end
  end

  assign link_rd.en   = accept && mode == MODE_ALLOC && alloc_ok;
  assign link_rd.addr = head[ADDR_W-1:0];

  assign div_req.start = accept && mode == MODE_REBUILD && slot_size != '0;
  assign div_req.numer = rounded - NUM_W'(HEADER_BYTES);
  assign div_req.denom = slot_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head       <= LIST_EMPTY;
      capacity   <= '0;
      slot_size  <= SIZE_RESET;
      built_size <= SIZE_RESET;
    end else begin
      if (cfg_write_en) begin
        slot_size <= cfg_write_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            status  <= STATUS_OK;
            grant   <= 1'b0;
            granted <= '0;
            product <= '0;
            state   <= ST_RESP;
            case (mode)
              MODE_ALLOC: begin
                if (alloc_ok) begin
                  grant   <= 1'b1;
                  granted <= head[INDEX_W-1:0];
                  product <= head[INDEX_W-1:0] * built_size;
                  state   <= ST_ALLOC_RD;
                end else begin
                  status <= STATUS_EMPTY;
                end
              end
              MODE_FREE: begin
                if (free_ok) begin
                  head <= LINK_W'(slot_index);
                end else begin
                  status <= STATUS_RANGE;
                end
              end
              MODE_REBUILD: begin
                built_size <= slot_size;
                if (slot_size == '0) begin
                  capacity <= '0;
                  head     <= LIST_EMPTY;
                end else begin
                  state <= ST_DIVIDE;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_ALLOC_RD: begin
          head  <= link_data;
          state <= ST_RESP;
        end
        ST_DIVIDE: begin
          if (div_rsp.done) begin
            capacity  <= cap_next;
            chain_idx <= '0;
            if (cap_next == '0) begin
              head  <= LIST_EMPTY;
              state <= ST_RESP;
            end else begin
              state <= ST_CHAIN;
            end
          end
        end
        ST_CHAIN: begin
          chain_idx <= chain_idx + ADDR_W'(1);
          if (chain_last) begin
            head  <= '0;
            state <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (resp_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign resp_valid      = (state == ST_RESP);
  assign resp.status     = status;
  assign resp.grant      = grant;
  assign resp.granted    = granted;
  assign resp.product    = product;
  assign resp.slot_count = capacity;

endmodule

### hdl/fixed_slot_free_list_allocator.sv
// Fixed-slot free-list allocator, top level with the output word register.
// Each word passes through the controller states in order: free, no-op and
// zero-size rebuild go straight to the response; allocate adds a link memory
// read; rebuild runs the 18-step divider, then one link write per slot.
// A word is taken only once the previous one has left the controller.
// Reset is synchronous: empty list, capacity 0, slot size 16; link memory uncleared.
module fixed_slot_free_list_allocator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [fsfl_pkg::SIZE_W-1:0]     cfg_write_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [fsfl_pkg::MODE_W-1:0]     mode,
  input  logic [fsfl_pkg::INDEX_W-1:0]    slot_index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [fsfl_pkg::STATUS_W-1:0]   status,
  output logic [fsfl_pkg::INDEX_W-1:0]    granted_index,
  output logic [fsfl_pkg::OFFSET_W-1:0]   byte_offset,
  output logic [fsfl_pkg::COUNT_W-1:0]    slot_count
);
  import fsfl_pkg::*;

  link_wr_t          link_wr;
  link_rd_t          link_rd;
  logic [LINK_W-1:0] link_data;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic              resp_valid;
  logic              resp_ready;
  resp_t             resp;

  fsfl_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .slot_index     (slot_index),
    .link_wr        (link_wr),
    .link_rd        (link_rd),
    .link_data      (link_data),
    .div_req        (div_req),
    .div_rsp        (div_rsp),
    .resp_valid     (resp_valid),
    .resp_ready     (resp_ready),
    .resp           (resp)
  );

  fsfl_link_mem u_link_mem (
    .clk     (clk),
    .wr      (link_wr),
    .rd      (link_rd),
    .rd_data (link_data)
  );

  fsfl_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign resp_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (resp_valid && resp_ready) begin
        out_valid     <= 1'b1;
        status        <= resp.status;
        granted_index <= resp.granted;
        byte_offset   <= resp.grant ? OFFSET_W'(HEADER_BYTES) + OFFSET_W'(resp.product)
                                    : '0;
        slot_count    <= resp.slot_count;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_fail_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_OK |-> granted_index == '0 && byte_offset == '0)
    else $error("failed word carries a grant");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> slot_count <= COUNT_W'(MAX_SLOTS))
    else $error("slot count above maximum");

  a_grant_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_OK && granted_index != '0 |->
      COUNT_W'(granted_index) < slot_count)
    else $error("granted slot outside capacity");
`endif

endmodule
